// ===== design/ipid_pkg.sv =====
// Shared types, widths and register codes for the incremental PID controller.
// No dependencies; imported by the controller and its checker.
`default_nettype none

package ipid_pkg;

  localparam int TEMP_WIDTH  = 16;
  localparam int FRAC_BITS   = 8;
  localparam int COEF_WIDTH  = 16;
  localparam int DRIVE_WIDTH = 15;
  localparam int FULL_SCALE  = 100;

  localparam int CFG_WIDTH    = (TEMP_WIDTH > COEF_WIDTH) ? TEMP_WIDTH : COEF_WIDTH;
  localparam int ERR_WIDTH    = TEMP_WIDTH + 1;
  localparam int PROD_WIDTH   = COEF_WIDTH + ERR_WIDTH;
  localparam int SCALED_WIDTH = PROD_WIDTH - FRAC_BITS;
  localparam int FULL_WIDTH   = 8 + FRAC_BITS;
  localparam int SUM_BASE_A   = (SCALED_WIDTH > FULL_WIDTH) ? SCALED_WIDTH : FULL_WIDTH;
  localparam int SUM_BASE     = (SUM_BASE_A > DRIVE_WIDTH + 1) ? SUM_BASE_A : DRIVE_WIDTH + 1;
  localparam int SUM_WIDTH    = SUM_BASE + 3;

  localparam logic signed [SUM_WIDTH-1:0] DRIVE_FULL = SUM_WIDTH'(FULL_SCALE) << FRAC_BITS;

  typedef enum logic [1:0] {
    REG_SETPOINT      = 2'd0,
    REG_COEF_CURRENT  = 2'd1,
    REG_COEF_PREVIOUS = 2'd2,
    REG_COEF_OLDER    = 2'd3
  } cfg_index_t;

  localparam logic signed [TEMP_WIDTH-1:0] SETPOINT_RESET     = TEMP_WIDTH'(8960);
  localparam logic signed [COEF_WIDTH-1:0] COEF_CURRENT_RESET = COEF_WIDTH'(4096);

endpackage

`default_nettype wire

// ===== design/incremental_pid_clamped.sv =====
// Velocity-form PID controller with drive clamp, one tick per input beat.
// Depends on ipid_pkg for widths, register codes and the full-scale constant.
`default_nettype none

// Each input beat is one control tick carrying a signed Q8.8 temperature. The
// beat is captured in an input register; from there three multipliers form
// the weighted errors, an adder tree adds them to the previous drive, and the
// clamped drive and its zero flag land in the result register, while the error
// history and stored drive update in the same edge. A new beat is taken every
// cycle as long as the result side keeps draining. Configuration writes
// (setpoint and the three coefficients, index 0..3) take effect at once and are
// always accepted.
module incremental_pid_clamped (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire  [ipid_pkg::TEMP_WIDTH-1:0]       measured_temp,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic [ipid_pkg::DRIVE_WIDTH-1:0]      drive,
  output logic                                  zero_drive,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire  ipid_pkg::cfg_index_t            cfg_index,
  input  wire  [ipid_pkg::CFG_WIDTH-1:0]        cfg_data
);
  import ipid_pkg::*;

  // configuration
  logic signed [TEMP_WIDTH-1:0] setpoint;
  logic signed [COEF_WIDTH-1:0] coef_current;
  logic signed [COEF_WIDTH-1:0] coef_previous;
  logic signed [COEF_WIDTH-1:0] coef_older;

  // state
  logic signed [ERR_WIDTH-1:0]  error_last;
  logic signed [ERR_WIDTH-1:0]  error_older;
  logic [DRIVE_WIDTH-1:0]       drive_last;

  // input register
  logic                         meas_valid;
  logic signed [TEMP_WIDTH-1:0] meas;

  logic advance;

  logic signed [ERR_WIDTH-1:0]    e0;
  logic signed [PROD_WIDTH-1:0]   p0, p1, p2;
  logic signed [SCALED_WIDTH-1:0] sc0, sc1, sc2;
  logic signed [SUM_WIDTH-1:0]    sum;
  logic signed [SUM_WIDTH-1:0]    clamped;
  logic                           forced;
  logic [DRIVE_WIDTH-1:0]         drive_next;

  assign cfg_ready = 1'b1;
  assign advance   = meas_valid && (!out_valid || out_ready);
  assign in_ready  = !meas_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint      <= SETPOINT_RESET;
      coef_current  <= COEF_CURRENT_RESET;
      coef_previous <= '0;
      coef_older    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SETPOINT:      setpoint      <= cfg_data[TEMP_WIDTH-1:0];
        REG_COEF_CURRENT:  coef_current  <= cfg_data[COEF_WIDTH-1:0];
        REG_COEF_PREVIOUS: coef_previous <= cfg_data[COEF_WIDTH-1:0];
        REG_COEF_OLDER:    coef_older    <= cfg_data[COEF_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meas_valid <= 1'b0;
    end else if (in_ready) begin
      meas_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      meas <= measured_temp;
    end
  end

  // error and weighted terms; floor scaling is a plain bit drop
  assign e0  = {setpoint[TEMP_WIDTH-1], setpoint} - {meas[TEMP_WIDTH-1], meas};
  assign p0  = coef_current * e0;
  assign p1  = coef_previous * error_last;
  assign p2  = coef_older * error_older;
  assign sc0 = p0[PROD_WIDTH-1:FRAC_BITS];
  assign sc1 = p1[PROD_WIDTH-1:FRAC_BITS];
  assign sc2 = p2[PROD_WIDTH-1:FRAC_BITS];

  assign sum = {{(SUM_WIDTH-DRIVE_WIDTH){1'b0}}, drive_last}
             + {{(SUM_WIDTH-SCALED_WIDTH){sc0[SCALED_WIDTH-1]}}, sc0}
             + {{(SUM_WIDTH-SCALED_WIDTH){sc1[SCALED_WIDTH-1]}}, sc1}
             + {{(SUM_WIDTH-SCALED_WIDTH){sc2[SCALED_WIDTH-1]}}, sc2};

  always_comb begin
    forced  = 1'b0;
    clamped = sum;
    if (sum >= DRIVE_FULL) begin
      clamped = DRIVE_FULL;
    end
    if (sum[SUM_WIDTH-1] || (sum == '0) || (e0 == '0)) begin
      clamped = '0;
      forced  = 1'b1;
    end
    drive_next = clamped[DRIVE_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_last  <= '0;
      error_older <= '0;
      drive_last  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (advance) begin
        error_older <= error_last;
        error_last  <= e0;
        drive_last  <= drive_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid   <= 1'b0;
      end
    end
  end

  // result payload; hold while the beat is stalled
  always_ff @(posedge clk) begin
    if (advance) begin
      drive      <= drive_next;
      zero_drive <= forced;
    end
  end

endmodule

`default_nettype wire

// ===== design/ipid_checker.sv =====
// Port-level checks for incremental_pid_clamped, attached by bind.
// Depends on ipid_pkg for the drive width and full-scale constant.
`default_nettype none

module ipid_checker (
  input wire                                clk,
  input wire                                rst,
  input wire                                in_ready,
  input wire                                out_valid,
  input wire                                out_ready,
  input wire [ipid_pkg::DRIVE_WIDTH-1:0]    drive,
  input wire                                zero_drive
);
  import ipid_pkg::*;

  // a forced result always carries zero drive
  assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_drive |-> drive == '0)
    else $error("zero_drive set with nonzero drive");

  // drive never exceeds full scale
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> SUM_WIDTH'(drive) <= DRIVE_FULL)
    else $error("drive above full scale");

  // with the result side empty the input side never stalls
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while result register empty");

  // no result right after reset
  assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(drive) && $stable(zero_drive))
    else $error("stalled result beat changed");

endmodule

bind incremental_pid_clamped ipid_checker u_ipid_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .drive      (drive),
  .zero_drive (zero_drive)
);

`default_nettype wire
